@@ sv/gacq_pkg.sv @@
`default_nettype none
package gacq_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_CAMERA  = 2'd1;
   localparam logic [1:0] OP_READING = 2'd2;
   localparam logic [1:0] OP_COMMAND = 2'd3;

   localparam logic [7:0] BYTE_SIGHT   = 8'h56;
   localparam logic [7:0] BYTE_OPEN_U  = 8'h4F;
   localparam logic [7:0] BYTE_OPEN_L  = 8'h6F;
   localparam logic [7:0] BYTE_CLOSE_U = 8'h43;
   localparam logic [7:0] BYTE_CLOSE_L = 8'h63;
   localparam logic [7:0] BYTE_REARM_U = 8'h52;
   localparam logic [7:0] BYTE_REARM_L = 8'h72;

   localparam logic [2:0] CSR_WINDOW_MIN   = 3'd0;
   localparam logic [2:0] CSR_WINDOW_MAX   = 3'd1;
   localparam logic [2:0] CSR_REQ_HITS     = 3'd2;
   localparam logic [2:0] CSR_FRESH_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_HOLD_TIME    = 3'd4;
   localparam logic [2:0] CSR_OPEN_ANGLE   = 3'd5;
   localparam logic [2:0] CSR_CLOSED_ANGLE = 3'd6;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [9:0]  MS_SAT      = 10'h3FF;
   localparam logic [7:0]  MAX_ANGLE   = 8'd180;
   localparam logic [11:0] TICK_MIN    = 12'd205;
   // 205 * ceil(2^23 / 180), exact floor(205 * a / 180) for a up to 180
   localparam logic [23:0] TICK_RECIP  = 24'd9553820;
   localparam int          TICK_SHIFT  = 23;

   localparam logic [15:0] RST_WINDOW_MIN   = 16'd56;
   localparam logic [15:0] RST_WINDOW_MAX   = 16'd60;
   localparam logic [2:0]  RST_REQ_HITS     = 3'd3;
   localparam logic [9:0]  RST_FRESH_LIMIT  = 10'd300;
   localparam logic [9:0]  RST_HOLD_TIME    = 10'd150;
   localparam logic [7:0]  RST_OPEN_ANGLE   = 8'd0;
   localparam logic [7:0]  RST_CLOSED_ANGLE = 8'd65;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  byte_value;
      logic [15:0] distance_mm;
      logic        reading_valid;
   } req_word_type;

   typedef struct packed {
      logic        claw_closed;
      logic [11:0] servo_ticks;
      logic        camera_confirmed;
      logic [2:0]  hit_count;
      logic        auto_fired;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] window_min_mm;
      logic [15:0] window_max_mm;
      logic [2:0]  required_hits;
      logic [9:0]  fresh_limit_ms;
      logic [9:0]  hold_time_ms;
      logic [7:0]  open_angle;
      logic [7:0]  closed_angle;
   } cfg_type;

endpackage
`default_nettype wire

@@ sv/gacq_servo.sv @@
`default_nettype none
module gacq_servo (
   input  wire logic [7:0]  angle,
   output logic      [11:0] ticks
);

   logic [7:0]  angle_clamped;
   logic [31:0] scaled;

   always_comb begin
      angle_clamped = (angle > gacq_pkg::MAX_ANGLE) ? gacq_pkg::MAX_ANGLE : angle;
      scaled = {24'd0, angle_clamped} * {8'd0, gacq_pkg::TICK_RECIP};
      ticks = gacq_pkg::TICK_MIN
            + {4'd0, scaled[gacq_pkg::TICK_SHIFT + 7 : gacq_pkg::TICK_SHIFT]};
   end

endmodule
`default_nettype wire

@@ sv/gacq_core.sv @@
`default_nettype none
module gacq_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gacq_pkg::cfg_type      cfg,
   input  wire gacq_pkg::req_word_type item,
   input  wire logic                   advance,
   output gacq_pkg::rsp_word_type      result
);

   logic [9:0] since_ff, since_in;
   logic       active_ff, active_in;
   logic [9:0] sustain_ff, sustain_in;
   logic [2:0] hits_ff, hits_in;
   logic       closed_ff, closed_in;
   logic       armed_ff, armed_in;

   logic       eval;
   logic       tick;
   logic       fresh;
   logic       in_window;
   logic       confirmed;
   logic       fired;
   logic [7:0] angle;
   logic [11:0] ticks;

   always_comb begin
      since_in   = since_ff;
      active_in  = active_ff;
      sustain_in = sustain_ff;
      hits_in    = hits_ff;
      closed_in  = closed_ff;
      armed_in   = armed_ff;
      eval       = 1'b0;
      tick       = 1'b0;
      in_window  = item.reading_valid
                 && (item.distance_mm >= cfg.window_min_mm)
                 && (item.distance_mm <= cfg.window_max_mm);

      case (item.opcode)
         gacq_pkg::OP_TICK: begin
            if (since_ff < gacq_pkg::MS_SAT) since_in = since_ff + 10'd1;
            eval = 1'b1;
            tick = 1'b1;
         end
         gacq_pkg::OP_CAMERA: begin
            if (item.byte_value == gacq_pkg::BYTE_SIGHT) begin
               since_in = 10'd0;
               eval = 1'b1;
            end
         end
         gacq_pkg::OP_READING: begin
            if (in_window) begin
               if (hits_ff < cfg.required_hits) hits_in = hits_ff + 3'd1;
            end else begin
               hits_in = 3'd0;
               if (closed_ff) armed_in = 1'b1;
            end
         end
         default: begin
            if (item.byte_value == gacq_pkg::BYTE_OPEN_U
                  || item.byte_value == gacq_pkg::BYTE_OPEN_L) begin
               closed_in = 1'b0;
               hits_in   = 3'd0;
               armed_in  = 1'b1;
            end else if (item.byte_value == gacq_pkg::BYTE_CLOSE_U
                  || item.byte_value == gacq_pkg::BYTE_CLOSE_L) begin
               closed_in = 1'b1;
            end else if (item.byte_value == gacq_pkg::BYTE_REARM_U
                  || item.byte_value == gacq_pkg::BYTE_REARM_L) begin
               armed_in = 1'b1;
               hits_in  = 3'd0;
            end
         end
      endcase

      fresh = (since_in < gacq_pkg::MS_SAT) && (since_in <= cfg.fresh_limit_ms);
      if (eval) begin
         if (fresh) begin
            if (!active_ff) begin
               active_in  = 1'b1;
               sustain_in = 10'd0;
            end else if (tick && sustain_ff < gacq_pkg::MS_SAT) begin
               sustain_in = sustain_ff + 10'd1;
            end
         end else begin
            active_in  = 1'b0;
            sustain_in = 10'd0;
         end
      end

      confirmed = active_in && (sustain_in >= cfg.hold_time_ms);
      fired = armed_in && !closed_in && confirmed && (hits_in >= cfg.required_hits);
      if (fired) begin
         closed_in = 1'b1;
         armed_in  = 1'b0;
      end

      angle = closed_in ? cfg.closed_angle : cfg.open_angle;
   end

   gacq_servo u_servo (
      .angle (angle),
      .ticks (ticks)
   );

   always_comb begin
      result.claw_closed      = closed_in;
      result.servo_ticks      = ticks;
      result.camera_confirmed = confirmed;
      result.hit_count        = hits_in;
      result.auto_fired       = fired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff   <= gacq_pkg::MS_SAT;
         active_ff  <= 1'b0;
         sustain_ff <= 10'd0;
         hits_ff    <= 3'd0;
         closed_ff  <= 1'b0;
         armed_ff   <= 1'b1;
      end else if (advance) begin
         since_ff   <= since_in;
         active_ff  <= active_in;
         sustain_ff <= sustain_in;
         hits_ff    <= hits_in;
         closed_ff  <= closed_in;
         armed_ff   <= armed_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/gripper_auto_close_qualifier.sv @@
// Gripper auto-close qualifier. Takes one word per cycle (ticks, camera bytes,
// distance readings, commands) unless stalled by rsp_ready, and returns exactly
// one result word for each. A word is registered on entry, evaluated against the
// qualifier state in a single pass and registered on exit; the input register
// advances into the output register once that is empty or draining. A new word
// is accepted every cycle while the result register drains; the combinational
// path from rsp_ready to req_ready is the only backpressure link. The servo
// on-tick count comes from a constant reciprocal multiply of the clamped angle.
// Configuration registers are written through the csr_ channel, always ready,
// and must only be changed while no words are in flight.
`default_nettype none
module gripper_auto_close_qualifier (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire gacq_pkg::req_word_type                   req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output gacq_pkg::rsp_word_type                        rsp_data,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [gacq_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [gacq_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   gacq_pkg::cfg_type      cfg_ff;
   gacq_pkg::req_word_type in_data_ff;
   gacq_pkg::rsp_word_type out_data_ff;
   gacq_pkg::rsp_word_type result;
   logic                   in_valid_ff;
   logic                   out_valid_ff;
   logic                   advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_min_mm  <= gacq_pkg::RST_WINDOW_MIN;
         cfg_ff.window_max_mm  <= gacq_pkg::RST_WINDOW_MAX;
         cfg_ff.required_hits  <= gacq_pkg::RST_REQ_HITS;
         cfg_ff.fresh_limit_ms <= gacq_pkg::RST_FRESH_LIMIT;
         cfg_ff.hold_time_ms   <= gacq_pkg::RST_HOLD_TIME;
         cfg_ff.open_angle     <= gacq_pkg::RST_OPEN_ANGLE;
         cfg_ff.closed_angle   <= gacq_pkg::RST_CLOSED_ANGLE;
      end else if (csr_valid) begin
         unique case (csr_index)
            gacq_pkg::CSR_WINDOW_MIN:   cfg_ff.window_min_mm  <= csr_data;
            gacq_pkg::CSR_WINDOW_MAX:   cfg_ff.window_max_mm  <= csr_data;
            gacq_pkg::CSR_REQ_HITS:     cfg_ff.required_hits  <= csr_data[2:0];
            gacq_pkg::CSR_FRESH_LIMIT:  cfg_ff.fresh_limit_ms <= csr_data[9:0];
            gacq_pkg::CSR_HOLD_TIME:    cfg_ff.hold_time_ms   <= csr_data[9:0];
            gacq_pkg::CSR_OPEN_ANGLE:   cfg_ff.open_angle     <= csr_data[7:0];
            gacq_pkg::CSR_CLOSED_ANGLE: cfg_ff.closed_angle   <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   gacq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (in_data_ff),
      .advance (advance),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule
`default_nettype wire

@@ verif/tb_gripper_auto_close_qualifier.sv @@
`timescale 1ns / 100ps
module tb_gripper_auto_close_qualifier;
   import gacq_pkg::*;

   localparam int SERVO_SPAN      = 205;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int MAX_REPORTS     = 10;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   // shadow of the qualifier
   cfg_type shadow_cfg;
   logic [9:0] sight_age_ms;
   logic sustain_on;
   logic [9:0] sustain_ms_cnt;
   logic [2:0] grip_hits;
   logic claw_shut;
   logic auto_armed;

   rsp_word_type pending_claw_rsp[$];
   int mismatch_count = 0;
   int sent_words = 0;
   bit req_gaps_on;
   bit rsp_stalls_on;
   bit hold_off_pending;
   bit holding_off;

   gripper_auto_close_qualifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void reset_claw_shadow();
      shadow_cfg.window_min_mm  = RST_WINDOW_MIN;
      shadow_cfg.window_max_mm  = RST_WINDOW_MAX;
      shadow_cfg.required_hits  = RST_REQ_HITS;
      shadow_cfg.fresh_limit_ms = RST_FRESH_LIMIT;
      shadow_cfg.hold_time_ms   = RST_HOLD_TIME;
      shadow_cfg.open_angle     = RST_OPEN_ANGLE;
      shadow_cfg.closed_angle   = RST_CLOSED_ANGLE;
      sight_age_ms   = MS_SAT;
      sustain_on     = 1'b0;
      sustain_ms_cnt = '0;
      grip_hits      = '0;
      claw_shut      = 1'b0;
      auto_armed     = 1'b1;
   endfunction

   function automatic void refresh_sustain(input bit on_tick);
      bit fresh;
      fresh = (sight_age_ms < MS_SAT) && (sight_age_ms <= shadow_cfg.fresh_limit_ms);
      if (fresh) begin
         if (!sustain_on) begin
            sustain_on     = 1'b1;
            sustain_ms_cnt = '0;
         end else if (on_tick && sustain_ms_cnt < MS_SAT) begin
            sustain_ms_cnt = sustain_ms_cnt + 10'd1;
         end
      end else begin
         sustain_on     = 1'b0;
         sustain_ms_cnt = '0;
      end
   endfunction

   function automatic bit camera_holds();
      return sustain_on && (sustain_ms_cnt >= shadow_cfg.hold_time_ms);
   endfunction

   function automatic logic [11:0] servo_ticks_for(input logic [7:0] angle);
      int deg;
      deg = angle;
      if (deg > MAX_ANGLE) deg = MAX_ANGLE;
      return 12'(int'(TICK_MIN) + (SERVO_SPAN * deg) / int'(MAX_ANGLE));
   endfunction

   function automatic rsp_word_type claw_response(input req_word_type w);
      rsp_word_type r;
      bit fired;
      bit in_window;
      fired = 1'b0;
      case (w.opcode)
         OP_TICK: begin
            if (sight_age_ms < MS_SAT) sight_age_ms = sight_age_ms + 10'd1;
            refresh_sustain(1'b1);
         end
         OP_CAMERA: begin
            if (w.byte_value == BYTE_SIGHT) begin
               sight_age_ms = '0;
               refresh_sustain(1'b0);
            end
         end
         OP_READING: begin
            in_window = w.reading_valid && (w.distance_mm >= shadow_cfg.window_min_mm)
                        && (w.distance_mm <= shadow_cfg.window_max_mm);
            if (in_window) begin
               if (grip_hits < shadow_cfg.required_hits) grip_hits = grip_hits + 3'd1;
            end else begin
               grip_hits = '0;
               if (claw_shut) auto_armed = 1'b1;
            end
         end
         OP_COMMAND: begin
            case (w.byte_value)
               BYTE_OPEN_U, BYTE_OPEN_L: begin
                  claw_shut  = 1'b0;
                  grip_hits  = '0;
                  auto_armed = 1'b1;
               end
               BYTE_CLOSE_U, BYTE_CLOSE_L: begin
                  claw_shut = 1'b1;
               end
               BYTE_REARM_U, BYTE_REARM_L: begin
                  auto_armed = 1'b1;
                  grip_hits  = '0;
               end
               default: ;
            endcase
         end
      endcase
      if (auto_armed && !claw_shut && camera_holds()
          && grip_hits >= shadow_cfg.required_hits) begin
         claw_shut  = 1'b1;
         auto_armed = 1'b0;
         fired      = 1'b1;
      end
      r.claw_closed      = claw_shut;
      r.servo_ticks      = servo_ticks_for(claw_shut ? shadow_cfg.closed_angle
                                                     : shadow_cfg.open_angle);
      r.camera_confirmed = camera_holds();
      r.hit_count        = grip_hits;
      r.auto_fired       = fired;
      return r;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      bit bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_claw_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result word %h at %0t", rsp_data, $realtime);
         end else begin
            want = pending_claw_rsp.pop_front();
            bad = (rsp_data.claw_closed !== want.claw_closed)
                  || (rsp_data.servo_ticks !== want.servo_ticks)
                  || (rsp_data.camera_confirmed !== want.camera_confirmed)
                  || (rsp_data.hit_count !== want.hit_count)
                  || (rsp_data.auto_fired !== want.auto_fired);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch at %0t: expected closed=%0d ticks=%0d confirmed=%0d hits=%0d fired=%0d",
                           $realtime, want.claw_closed, want.servo_ticks,
                           want.camera_confirmed, want.hit_count, want.auto_fired);
                  $display("   got closed=%0d ticks=%0d confirmed=%0d hits=%0d fired=%0d",
                           rsp_data.claw_closed, rsp_data.servo_ticks,
                           rsp_data.camera_confirmed, rsp_data.hit_count,
                           rsp_data.auto_fired);
               end
            end
         end
      end
   end

   // receiver side
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            holding_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            holding_off = 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            stall = idle_len();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      gap = req_gaps_on ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pending_claw_rsp.push_back(claw_response(w));
      sent_words++;
   endtask

   task automatic send_tick();
      send_word('{OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom)});
   endtask

   task automatic send_camera(input logic [7:0] b);
      send_word('{OP_CAMERA, b, 16'($urandom), 1'($urandom)});
   endtask

   task automatic send_reading(input logic [15:0] mm, input logic vld);
      send_word('{OP_READING, 8'($urandom), mm, vld});
   endtask

   task automatic send_command(input logic [7:0] b);
      send_word('{OP_COMMAND, b, 16'($urandom), 1'($urandom)});
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (pending_claw_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_MIN:   shadow_cfg.window_min_mm  = value;
         CSR_WINDOW_MAX:   shadow_cfg.window_max_mm  = value;
         CSR_REQ_HITS:     shadow_cfg.required_hits  = value[2:0];
         CSR_FRESH_LIMIT:  shadow_cfg.fresh_limit_ms = value[9:0];
         CSR_HOLD_TIME:    shadow_cfg.hold_time_ms   = value[9:0];
         CSR_OPEN_ANGLE:   shadow_cfg.open_angle     = value[7:0];
         CSR_CLOSED_ANGLE: shadow_cfg.closed_angle   = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [15:0] lo, input logic [15:0] hi,
                                 input int need, input int fresh, input int hold,
                                 input int open_deg, input int shut_deg);
      write_reg(CSR_WINDOW_MIN, lo);
      write_reg(CSR_WINDOW_MAX, hi);
      write_reg(CSR_REQ_HITS, 16'(need));
      write_reg(CSR_FRESH_LIMIT, 16'(fresh));
      write_reg(CSR_HOLD_TIME, 16'(hold));
      write_reg(CSR_OPEN_ANGLE, 16'(open_deg));
      write_reg(CSR_CLOSED_ANGLE, 16'(shut_deg));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] window_distance();
      if (shadow_cfg.window_min_mm <= shadow_cfg.window_max_mm)
         return 16'($urandom_range(shadow_cfg.window_max_mm, shadow_cfg.window_min_mm));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] any_distance();
      case ($urandom_range(0, 3))
         0:       return shadow_cfg.window_min_mm - 16'd1;
         1:       return shadow_cfg.window_max_mm + 16'd1;
         2:       return 16'($urandom);
         default: return window_distance();
      endcase
   endfunction

   function automatic logic [7:0] any_command();
      case ($urandom_range(0, 6))
         0:       return BYTE_OPEN_U;
         1:       return BYTE_OPEN_L;
         2:       return BYTE_CLOSE_U;
         3:       return BYTE_CLOSE_L;
         4:       return BYTE_REARM_U;
         5:       return BYTE_REARM_L;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) send_tick();
      else if (r < 50) send_camera(($urandom_range(0, 3) == 0) ? 8'($urandom) : BYTE_SIGHT);
      else if (r < 85) send_reading(any_distance(), 1'($urandom_range(0, 7) != 0));
      else send_command(any_command());
   endtask

   // sighting, hold time, enough readings in window, then an invalid reading or a random command
   task automatic grip_attempt();
      send_camera(BYTE_SIGHT);
      repeat (int'(shadow_cfg.hold_time_ms) + $urandom_range(0, 2)) send_tick();
      repeat (int'(shadow_cfg.required_hits) + $urandom_range(0, 1))
         send_reading(window_distance(), 1'b1);
      if ($urandom_range(0, 1) == 0) send_reading(16'($urandom), 1'b0);
      else send_command(any_command());
   endtask

   task automatic test_directed_items();
      send_tick();
      send_camera(8'h00);
      send_camera(8'hFF);
      send_camera(BYTE_SIGHT);
      send_tick();
      send_reading(16'd55, 1'b1);
      send_reading(16'd56, 1'b1);
      send_reading(16'd60, 1'b1);
      send_reading(16'd58, 1'b0);
      send_reading(16'd61, 1'b1);
      send_reading(16'd0, 1'b1);
      send_reading(16'hFFFF, 1'b1);
      repeat (4) send_reading(16'd59, 1'b1);
      send_command(BYTE_CLOSE_U);
      send_reading(16'd61, 1'b1);
      send_command(BYTE_CLOSE_L);
      send_command(BYTE_OPEN_U);
      send_command(BYTE_OPEN_L);
      send_command(BYTE_REARM_U);
      send_command(BYTE_REARM_L);
      send_command(8'h00);
      send_command(8'hFF);
      drain_words();
   endtask

   task automatic test_extreme_settings();
      // zero hold, zero hits needed, zero-width window at bottom
      write_all_regs(16'd0, 16'd0, 0, 0, 0, 0, 180);
      send_camera(BYTE_SIGHT);
      send_tick();
      send_reading(16'd0, 1'b1);
      send_command(BYTE_OPEN_U);
      send_camera(BYTE_SIGHT);
      send_command(BYTE_OPEN_L);
      send_tick();
      drain_words();
      // window and hit count at the top of their ranges, long time limits, angles above the clamp
      write_all_regs(16'hFFFF, 16'hFFFF, 7, 1000, 1000, 255, 181);
      repeat (8) send_reading(16'hFFFF, 1'b1);
      send_reading(16'hFFFE, 1'b1);
      repeat (7) send_reading(16'hFFFF, 1'b1);
      send_command(BYTE_CLOSE_U);
      drain_words();
      // lowered hit requirement keeps the higher count
      write_reg(CSR_REQ_HITS, 16'd2);
      csr_valid <= 1'b0;
      send_tick();
      send_reading(16'hFFFF, 1'b1);
      send_reading(16'hFFFE, 1'b1);
      send_command(BYTE_OPEN_L);
      drain_words();
      // empty window
      write_all_regs(16'd100, 16'd50, 1, 300, 150, 90, 65);
      send_reading(16'd50, 1'b1);
      send_reading(16'd75, 1'b1);
      send_reading(16'd100, 1'b1);
      drain_words();
   endtask

   // never-seen age stays stale even at the widest freshness limit
   task automatic test_age_saturation();
      write_all_regs(16'd56, 16'd60, 1, 1023, 0, 0, 65);
      req_gaps_on = 1'b0;
      repeat (4) send_tick();
      send_reading(16'd58, 1'b1);
      send_command(BYTE_OPEN_U);
      drain_words();
      req_gaps_on = 1'b1;
      write_all_regs(RST_WINDOW_MIN, RST_WINDOW_MAX, RST_REQ_HITS, RST_FRESH_LIMIT,
                     RST_HOLD_TIME, RST_OPEN_ANGLE, RST_CLOSED_ANGLE);
   endtask

   task automatic test_random_setups(input int phases, input int words_per_phase);
      logic [15:0] lo, hi;
      int fresh, hold, target;
      for (int p = 0; p < phases; p++) begin
         lo = 16'($urandom_range(1, 300));
         if ($urandom_range(0, 5) == 0) hi = lo - 16'($urandom_range(1, lo));
         else hi = lo + 16'($urandom_range(0, 15));
         fresh = $urandom_range(0, 40);
         hold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, fresh);
         write_all_regs(lo, hi, $urandom_range(0, 7), fresh, hold,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(181, 255)
                                                    : $urandom_range(0, 180),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(181, 255)
                                                    : $urandom_range(0, 180));
         req_gaps_on   = (p % 4 == 0) || (p % 4 == 1);
         rsp_stalls_on = (p % 4 == 0) || (p % 4 == 2);
         target = sent_words + words_per_phase;
         while (sent_words < target) begin
            if ($urandom_range(0, 9) < 6) grip_attempt();
            else send_random_item();
         end
         drain_words();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_receiver_hold_off();
      hold_off_pending = 1'b1;
      while (!holding_off) @(posedge clock);
      req_gaps_on = 1'b0;
      repeat (30) send_random_item();
      drain_words();
      req_gaps_on = 1'b1;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      reset_claw_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_age_saturation();
      test_directed_items();
      test_extreme_settings();
      test_random_setups(6, 70);
      test_receiver_hold_off();

      drain_words();
      repeat (8) @(posedge clock);
      mismatch_count += pending_claw_rsp.size();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
